// ===== rtl/core/mih_pkg.sv =====
// ----------------------------------------------------------------------------
// mih_pkg
// Shared constants, codes and controller/datapath types of the host table.
// ----------------------------------------------------------------------------
`default_nettype none

package mih_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FLD_W       = 7;
	localparam int CALC_W      = ((CNT_W > FLD_W) ? CNT_W : FLD_W) + 1;
	localparam int MAC_W       = 48;
	localparam int IP_W        = 32;
	localparam int SEEN_W      = 32;
	localparam int ENTRY_W     = MAC_W + IP_W + SEEN_W;

	typedef enum logic [1:0] {
		KIND_ADD,
		KIND_REMOVE,
		KIND_READ,
		KIND_NONE
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_RANGE,
		STATUS_FULL
	} status_t;

	typedef enum logic [1:0] {
		CHG_NONE,
		CHG_IP,
		CHG_MAC
	} change_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_DISPATCH,
		CS_SEARCH,
		CS_COMPARE,
		CS_COPY_RD,
		CS_COPY_WR,
		CS_READ_WAIT,
		CS_DONE
	} ctl_state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_SEARCH,
		RD_COPY,
		RD_ENTRY
	} rd_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_APPEND,
		WR_UPDATE,
		WR_COPY
	} wr_op_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_EMPTY,
		RES_RANGE,
		RES_FULL,
		RES_APPEND,
		RES_MATCH,
		RES_READ
	} res_op_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_FIRST,
		IDX_INC
	} idx_op_t;

	typedef struct packed {
		logic    load;
		idx_op_t idx_op;
		rd_op_t  rd_op;
		wr_op_t  wr_op;
		res_op_t res_op;
		logic    total_inc;
		logic    total_sub;
		logic    publish;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  empty_host;
		logic  search_end;
		logic  table_full;
		logic  match;
		logic  remove_bad;
		logic  copy_end;
		logic  read_bad;
		logic  out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/mih_req_if.sv =====
// ----------------------------------------------------------------------------
// mih_req_if
// Request channel of the host table: valid/ready with the item payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mih_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [47:0] mac_address;
	logic [31:0] ip_address;
	logic [31:0] seen_time;
	logic [6:0]  first_index;
	logic [6:0]  entry_count;

	modport source (
		output valid, kind, mac_address, ip_address, seen_time, first_index, entry_count,
		input  ready
	);

	modport sink (
		input  valid, kind, mac_address, ip_address, seen_time, first_index, entry_count,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/mih_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mih_rsp_if
// Response channel of the host table: valid/ready with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mih_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [6:0]  entry_index;
	logic        was_added;
	logic [1:0]  changed_field;
	logic [47:0] read_mac;
	logic [31:0] read_ip;
	logic [31:0] read_seen;
	logic [6:0]  host_total;

	modport source (
		output valid, status, entry_index, was_added, changed_field, read_mac, read_ip,
		       read_seen, host_total,
		input  ready
	);

	modport sink (
		input  valid, status, entry_index, was_added, changed_field, read_mac, read_ip,
		       read_seen, host_total,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/mac_ip_host_table.sv =====
// ----------------------------------------------------------------------------
// mac_ip_host_table_core
// Host table of MAC/IPv4 entries with last-seen times, kept in arrival order.
// ----------------------------------------------------------------------------
//  channel | dir | modport | payload
//  req     | in  | sink    | kind, mac_address, ip_address, seen_time,
//          |     |         | first_index, entry_count
//  rsp     | out | source  | status, entry_index, was_added, changed_field,
//          |     |         | read_mac, read_ip, read_seen, host_total
//
//  One item at a time. Add: each entry scanned is a RAM read, then a compare;
//  a match updates the entry; a scan end appends or reports a full table.
//  Remove: each entry at or above first_index + entry_count is copied down
//  (RAM read, then write). Read: one RAM read. Reset clears the host count,
//  result valid and controller state; entry RAM is not cleared. A result
//  waits in the output register; a new transaction is taken meanwhile, but
//  its result is held back until the previous one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mac_ip_host_table_core (
	input  wire logic clk,
	input  wire logic arst_n,
	mih_req_if.sink   req,
	mih_rsp_if.source rsp
);

	mih_pkg::dp_cmd_t  cmd;
	mih_pkg::dp_stat_t stat;

	mih_controller u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mih_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.kind          (req.kind),
		.mac_address   (req.mac_address),
		.ip_address    (req.ip_address),
		.seen_time     (req.seen_time),
		.first_index   (req.first_index),
		.entry_count   (req.entry_count),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.status        (rsp.status),
		.entry_index   (rsp.entry_index),
		.was_added     (rsp.was_added),
		.changed_field (rsp.changed_field),
		.read_mac      (rsp.read_mac),
		.read_ip       (rsp.read_ip),
		.read_seen     (rsp.read_seen),
		.host_total    (rsp.host_total)
	);

endmodule

`default_nettype wire

// ===== rtl/core/mih_ram.sv =====
// ----------------------------------------------------------------------------
// mih_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mih_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mih_datapath.sv =====
// ----------------------------------------------------------------------------
// mih_datapath
// Item registers, entry RAM, host count, scan index and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mih_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mih_pkg::dp_cmd_t  cmd,
	output mih_pkg::dp_stat_t      stat,
	input  wire logic [1:0]        kind,
	input  wire logic [47:0]       mac_address,
	input  wire logic [31:0]       ip_address,
	input  wire logic [31:0]       seen_time,
	input  wire logic [6:0]        first_index,
	input  wire logic [6:0]        entry_count,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic [1:0]             status,
	output logic [6:0]             entry_index,
	output logic                   was_added,
	output logic [1:0]             changed_field,
	output logic [47:0]            read_mac,
	output logic [31:0]            read_ip,
	output logic [31:0]            read_seen,
	output logic [6:0]             host_total
);

	mih_pkg::kind_t                 kind_q;
	logic [mih_pkg::MAC_W-1:0]      mac_q;
	logic [mih_pkg::IP_W-1:0]       ip_q;
	logic [mih_pkg::SEEN_W-1:0]     seen_q;
	logic [mih_pkg::FLD_W-1:0]      first_q;
	logic [mih_pkg::FLD_W-1:0]      count_q;
	logic [mih_pkg::CNT_W-1:0]      valid_total_q;
	logic [mih_pkg::CNT_W-1:0]      idx_q;

	mih_pkg::status_t               res_status_q;
	logic [mih_pkg::FLD_W-1:0]      res_index_q;
	logic                           res_added_q;
	mih_pkg::change_t               res_change_q;
	logic [mih_pkg::MAC_W-1:0]      res_mac_q;
	logic [mih_pkg::IP_W-1:0]       res_ip_q;
	logic [mih_pkg::SEEN_W-1:0]     res_seen_q;

	logic                           rsp_valid_q;
	logic [1:0]                     status_q;
	logic [mih_pkg::FLD_W-1:0]      entry_index_q;
	logic                           was_added_q;
	logic [1:0]                     changed_field_q;
	logic [mih_pkg::MAC_W-1:0]      read_mac_q;
	logic [mih_pkg::IP_W-1:0]       read_ip_q;
	logic [mih_pkg::SEEN_W-1:0]     read_seen_q;
	logic [mih_pkg::FLD_W-1:0]      host_total_q;

	logic [mih_pkg::CALC_W-1:0]     first_ext;
	logic [mih_pkg::CALC_W-1:0]     count_ext;
	logic [mih_pkg::CALC_W-1:0]     total_ext;
	logic [mih_pkg::CALC_W-1:0]     idx_ext;
	logic [mih_pkg::CALC_W-1:0]     copy_src;

	logic                           ram_we;
	logic [mih_pkg::IDX_W-1:0]      ram_waddr;
	logic [mih_pkg::ENTRY_W-1:0]    ram_wdata;
	logic                           ram_re;
	logic [mih_pkg::IDX_W-1:0]      ram_raddr;
	logic [mih_pkg::ENTRY_W-1:0]    ram_rdata;

	logic [mih_pkg::MAC_W-1:0]      rd_mac;
	logic [mih_pkg::IP_W-1:0]       rd_ip;
	logic [mih_pkg::SEEN_W-1:0]     rd_seen;
	logic [mih_pkg::ENTRY_W-1:0]    upd_entry;
	mih_pkg::change_t               upd_change;

	assign first_ext = mih_pkg::CALC_W'(first_q);
	assign count_ext = mih_pkg::CALC_W'(count_q);
	assign total_ext = mih_pkg::CALC_W'(valid_total_q);
	assign idx_ext   = mih_pkg::CALC_W'(idx_q);
	assign copy_src  = idx_ext + count_ext;

	assign rd_mac  = ram_rdata[mih_pkg::ENTRY_W-1 -: mih_pkg::MAC_W];
	assign rd_ip   = ram_rdata[mih_pkg::SEEN_W +: mih_pkg::IP_W];
	assign rd_seen = ram_rdata[mih_pkg::SEEN_W-1:0];

	assign stat.kind       = kind_q;
	assign stat.empty_host = (mac_q == '0) && (ip_q == '0);
	assign stat.search_end = idx_ext >= total_ext;
	assign stat.table_full = total_ext >= mih_pkg::CALC_W'(mih_pkg::TABLE_DEPTH);
	assign stat.match      = (rd_mac == mac_q) || (rd_ip == ip_q);
	assign stat.remove_bad = (first_ext + count_ext) > total_ext;
	assign stat.copy_end   = copy_src >= total_ext;
	assign stat.read_bad   = first_ext >= total_ext;
	assign stat.out_free   = !rsp_valid_q || rsp_ready;

	always_comb begin
		if (rd_ip != ip_q) begin
			upd_entry  = {rd_mac, ip_q, seen_q};
			upd_change = mih_pkg::CHG_IP;
		end else if (rd_mac != mac_q) begin
			upd_entry  = {mac_q, rd_ip, seen_q};
			upd_change = mih_pkg::CHG_MAC;
		end else begin
			upd_entry  = {rd_mac, rd_ip, seen_q};
			upd_change = mih_pkg::CHG_NONE;
		end
	end

	always_comb begin
		ram_re = cmd.rd_op != mih_pkg::RD_NONE;
		unique case (cmd.rd_op)
			mih_pkg::RD_SEARCH: ram_raddr = idx_q[mih_pkg::IDX_W-1:0];
			mih_pkg::RD_COPY:   ram_raddr = copy_src[mih_pkg::IDX_W-1:0];
			mih_pkg::RD_ENTRY:  ram_raddr = first_ext[mih_pkg::IDX_W-1:0];
			default:            ram_raddr = '0;
		endcase
	end

	always_comb begin
		ram_we = cmd.wr_op != mih_pkg::WR_NONE;
		unique case (cmd.wr_op)
			mih_pkg::WR_APPEND: begin
				ram_waddr = valid_total_q[mih_pkg::IDX_W-1:0];
				ram_wdata = {mac_q, ip_q, seen_q};
			end
			mih_pkg::WR_UPDATE: begin
				ram_waddr = idx_q[mih_pkg::IDX_W-1:0];
				ram_wdata = upd_entry;
			end
			mih_pkg::WR_COPY: begin
				ram_waddr = idx_q[mih_pkg::IDX_W-1:0];
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_waddr = '0;
				ram_wdata = ram_rdata;
			end
		endcase
	end

	mih_ram #(
		.WIDTH (mih_pkg::ENTRY_W),
		.DEPTH (mih_pkg::TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= mih_pkg::kind_t'(kind);
			mac_q   <= mac_address;
			ip_q    <= ip_address;
			seen_q  <= seen_time;
			first_q <= first_index;
			count_q <= entry_count;
		end
		unique case (cmd.idx_op)
			mih_pkg::IDX_ZERO:  idx_q <= '0;
			mih_pkg::IDX_FIRST: idx_q <= first_ext[mih_pkg::CNT_W-1:0];
			mih_pkg::IDX_INC:   idx_q <= idx_q + 1'b1;
			default:            idx_q <= idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= mih_pkg::STATUS_OK;
			res_index_q  <= '0;
			res_added_q  <= 1'b0;
			res_change_q <= mih_pkg::CHG_NONE;
			res_mac_q    <= '0;
			res_ip_q     <= '0;
			res_seen_q   <= '0;
		end else begin
			unique case (cmd.res_op)
				mih_pkg::RES_EMPTY: res_status_q <= mih_pkg::STATUS_EMPTY;
				mih_pkg::RES_RANGE: res_status_q <= mih_pkg::STATUS_RANGE;
				mih_pkg::RES_FULL:  res_status_q <= mih_pkg::STATUS_FULL;
				mih_pkg::RES_APPEND: begin
					res_index_q <= total_ext[mih_pkg::FLD_W-1:0];
					res_added_q <= 1'b1;
				end
				mih_pkg::RES_MATCH: begin
					res_index_q  <= idx_ext[mih_pkg::FLD_W-1:0];
					res_change_q <= upd_change;
				end
				mih_pkg::RES_READ: begin
					res_index_q <= first_q;
					res_mac_q   <= rd_mac;
					res_ip_q    <= rd_ip;
					res_seen_q  <= rd_seen;
				end
				default: begin
					res_status_q <= res_status_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_total_q <= '0;
		end else if (cmd.total_inc) begin
			valid_total_q <= valid_total_q + 1'b1;
		end else if (cmd.total_sub) begin
			valid_total_q <= valid_total_q - count_ext[mih_pkg::CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			status_q        <= res_status_q;
			entry_index_q   <= res_index_q;
			was_added_q     <= res_added_q;
			changed_field_q <= res_change_q;
			read_mac_q      <= res_mac_q;
			read_ip_q       <= res_ip_q;
			read_seen_q     <= res_seen_q;
			host_total_q    <= total_ext[mih_pkg::FLD_W-1:0];
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign entry_index   = entry_index_q;
	assign was_added     = was_added_q;
	assign changed_field = changed_field_q;
	assign read_mac      = read_mac_q;
	assign read_ip       = read_ip_q;
	assign read_seen     = read_seen_q;
	assign host_total    = host_total_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_ext <= mih_pkg::CALC_W'(mih_pkg::TABLE_DEPTH))
		else $error("host count above table depth");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!rsp_valid_q || rsp_ready))
		else $error("result overwritten before it was taken");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_op == mih_pkg::WR_APPEND) |-> !stat.table_full)
		else $error("append into full table");

	a_remove_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.total_sub |-> !stat.remove_bad)
		else $error("removal beyond host count");

endmodule

`default_nettype wire

// ===== rtl/core/mih_controller.sv =====
// ----------------------------------------------------------------------------
// mih_controller
// Sequencer for add (linear scan), remove (compaction copy) and read items.
// ----------------------------------------------------------------------------
`default_nettype none

module mih_controller (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mih_pkg::dp_stat_t stat,
	output mih_pkg::dp_cmd_t       cmd
);

	mih_pkg::ctl_state_t state_q;
	mih_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mih_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mih_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mih_pkg::CS_DISPATCH;
				end
			end
			mih_pkg::CS_DISPATCH: begin
				unique case (stat.kind)
					mih_pkg::KIND_ADD: begin
						if (stat.empty_host) begin
							cmd.res_op = mih_pkg::RES_EMPTY;
							state_d    = mih_pkg::CS_DONE;
						end else begin
							cmd.idx_op = mih_pkg::IDX_ZERO;
							state_d    = mih_pkg::CS_SEARCH;
						end
					end
					mih_pkg::KIND_REMOVE: begin
						if (stat.remove_bad) begin
							cmd.res_op = mih_pkg::RES_RANGE;
							state_d    = mih_pkg::CS_DONE;
						end else begin
							cmd.idx_op = mih_pkg::IDX_FIRST;
							state_d    = mih_pkg::CS_COPY_RD;
						end
					end
					mih_pkg::KIND_READ: begin
						if (stat.read_bad) begin
							cmd.res_op = mih_pkg::RES_RANGE;
							state_d    = mih_pkg::CS_DONE;
						end else begin
							cmd.rd_op = mih_pkg::RD_ENTRY;
							state_d   = mih_pkg::CS_READ_WAIT;
						end
					end
					default: begin
						state_d = mih_pkg::CS_DONE;
					end
				endcase
			end
			mih_pkg::CS_SEARCH: begin
				if (stat.search_end) begin
					if (stat.table_full) begin
						cmd.res_op = mih_pkg::RES_FULL;
					end else begin
						cmd.wr_op     = mih_pkg::WR_APPEND;
						cmd.res_op    = mih_pkg::RES_APPEND;
						cmd.total_inc = 1'b1;
					end
					state_d = mih_pkg::CS_DONE;
				end else begin
					cmd.rd_op = mih_pkg::RD_SEARCH;
					state_d   = mih_pkg::CS_COMPARE;
				end
			end
			mih_pkg::CS_COMPARE: begin
				if (stat.match) begin
					cmd.wr_op  = mih_pkg::WR_UPDATE;
					cmd.res_op = mih_pkg::RES_MATCH;
					state_d    = mih_pkg::CS_DONE;
				end else begin
					cmd.idx_op = mih_pkg::IDX_INC;
					state_d    = mih_pkg::CS_SEARCH;
				end
			end
			mih_pkg::CS_COPY_RD: begin
				if (stat.copy_end) begin
					cmd.total_sub = 1'b1;
					state_d       = mih_pkg::CS_DONE;
				end else begin
					cmd.rd_op = mih_pkg::RD_COPY;
					state_d   = mih_pkg::CS_COPY_WR;
				end
			end
			mih_pkg::CS_COPY_WR: begin
				cmd.wr_op  = mih_pkg::WR_COPY;
				cmd.idx_op = mih_pkg::IDX_INC;
				state_d    = mih_pkg::CS_COPY_RD;
			end
			mih_pkg::CS_READ_WAIT: begin
				cmd.res_op = mih_pkg::RES_READ;
				state_d    = mih_pkg::CS_DONE;
			end
			mih_pkg::CS_DONE: begin
				if (stat.out_free) begin
					cmd.publish = 1'b1;
					state_d     = mih_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = mih_pkg::CS_IDLE;
			end
		endcase
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == mih_pkg::CS_DISPATCH))
		else $error("accepted transaction not dispatched");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (state_q == mih_pkg::CS_IDLE))
		else $error("item loaded while another is in work");

	a_publish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> in_ready)
		else $error("not ready after result publish");

endmodule

`default_nettype wire
